### src/bstok_pkg.sv
// ----------------------------------------------------------------------------
// bstok_pkg
// Types, token codes and helper functions of the byte stream tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package bstok_pkg;

  localparam int unsigned PosW      = 32;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  localparam logic [63:0] FnvBasis  = 64'hcbf29ce484222325;
  // prime is 2^40 + 0x1b3, so the product is a shift plus a short constant product
  localparam int unsigned FnvShift  = 40;
  localparam logic [8:0]  FnvLow    = 9'h1b3;

  // token kinds
  localparam logic [4:0] KindEnd    = 5'd0;
  localparam logic [4:0] KindLParen = 5'd1;
  localparam logic [4:0] KindRParen = 5'd2;
  localparam logic [4:0] KindLBrack = 5'd3;
  localparam logic [4:0] KindRBrack = 5'd4;
  localparam logic [4:0] KindLBrace = 5'd5;
  localparam logic [4:0] KindRBrace = 5'd6;
  localparam logic [4:0] KindPlus   = 5'd7;
  localparam logic [4:0] KindMinus  = 5'd8;
  localparam logic [4:0] KindStar   = 5'd9;
  localparam logic [4:0] KindSlash  = 5'd10;
  localparam logic [4:0] KindEqual  = 5'd11;
  localparam logic [4:0] KindLess   = 5'd12;
  localparam logic [4:0] KindGreat  = 5'd13;
  localparam logic [4:0] KindBang   = 5'd14;
  localparam logic [4:0] KindDColon = 5'd15;
  localparam logic [4:0] KindString = 5'd16;
  localparam logic [4:0] KindTrue   = 5'd17;
  localparam logic [4:0] KindFalse  = 5'd18;
  localparam logic [4:0] KindDouble = 5'd19;
  localparam logic [4:0] KindInt    = 5'd20;
  localparam logic [4:0] KindVar    = 5'd21;
  localparam logic [4:0] KindFn     = 5'd22;
  localparam logic [4:0] KindMatch  = 5'd23;
  localparam logic [4:0] KindIdent  = 5'd24;
  localparam logic [4:0] KindStd    = 5'd25;
  localparam logic [4:0] KindFor    = 5'd26;

  // status codes
  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StUnexpected = 3'd1;
  localparam logic [2:0] StColon      = 3'd2;
  localparam logic [2:0] StDot        = 3'd3;
  localparam logic [2:0] StUnterm     = 3'd4;

  // characters
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChColon  = 8'h3a;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;

  // keywords, packed as the last identifier bytes
  localparam logic [39:0] KwVar   = 40'h0000766172;
  localparam logic [39:0] KwFn    = 40'h000000666e;
  localparam logic [39:0] KwMatch = 40'h6d61746368;
  localparam logic [39:0] KwStd   = 40'h0000737464;
  localparam logic [39:0] KwFor   = 40'h0000666f72;
  localparam logic [39:0] KwTrue  = 40'h0074727565;
  localparam logic [39:0] KwFalse = 40'h66616c7365;

  typedef enum logic [2:0] {
    ModeIdle    = 3'd0,
    ModeColon   = 3'd1,
    ModeNumber  = 3'd2,
    ModeIdent   = 3'd3,
    ModeQuoted  = 3'd4,
    ModeString  = 3'd5,
    ModeComment = 3'd6,
    ModeHalt    = 3'd7
  } mode_e;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] start;
    logic [31:0] length;
    logic [63:0] hash;
    logic [2:0]  status;
    logic        last;
  } result_t;

  function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << FnvShift) + (x * {55'd0, FnvLow});
  endfunction

  function automatic logic is_alnum(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7a) ||
           (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
  endfunction

  function automatic logic [4:0] punct_kind(logic [7:0] b);
    logic [4:0] k;
    unique case (b)
      8'h28:   k = KindLParen;
      8'h29:   k = KindRParen;
      8'h5b:   k = KindLBrack;
      8'h5d:   k = KindRBrack;
      8'h7b:   k = KindLBrace;
      8'h7d:   k = KindRBrace;
      8'h2b:   k = KindPlus;
      8'h2d:   k = KindMinus;
      8'h2a:   k = KindStar;
      8'h2f:   k = KindSlash;
      8'h3d:   k = KindEqual;
      8'h3c:   k = KindLess;
      8'h3e:   k = KindGreat;
      8'h21:   k = KindBang;
      default: k = KindEnd;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] ident_kind(logic [39:0] kw, logic too_long);
    logic [4:0] k;
    k = KindIdent;
    if (!too_long) begin
      priority case (kw)
        KwVar:   k = KindVar;
        KwFn:    k = KindFn;
        KwMatch: k = KindMatch;
        KwStd:   k = KindStd;
        KwFor:   k = KindFor;
        KwTrue:  k = KindTrue;
        KwFalse: k = KindFalse;
        default: k = KindIdent;
      endcase
    end
    return k;
  endfunction

  function automatic result_t make_result(logic [4:0] kind, logic [31:0] start,
                                          logic [31:0] length, logic [63:0] hash,
                                          logic [2:0] status);
    result_t r;
    r.kind   = kind;
    r.start  = start;
    r.length = length;
    r.hash   = hash;
    r.status = status;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

### src/bstok_in_if.sv
// ----------------------------------------------------------------------------
// bstok_in_if
// Source byte channel: one byte or end of input per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bstok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_marker;

  modport source (output valid, output data_byte, output end_marker, input ready);
  modport sink   (input valid, input data_byte, input end_marker, output ready);
endinterface

`default_nettype wire

### src/bstok_out_if.sv
// ----------------------------------------------------------------------------
// bstok_out_if
// Token channel: one token per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bstok_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [31:0] token_start;
  logic [31:0] token_length;
  logic [63:0] token_hash;
  logic [2:0]  status;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output token_hash, output status,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input token_hash, input status,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

### src/byte_stream_tokenizer_fnv_hash.sv
// ----------------------------------------------------------------------------
// byte_stream_tokenizer_fnv_hash
// Lexer over a byte stream with FNV-1a 64 token hashes.
//
//   channel  dir  payload                                           handshake
//   in_i     in   data_byte, end_marker                              valid/ready
//   out_o    out  token_kind/start/length/hash, status, last_of_run  valid/ready
//
// One byte is scanned per cycle while in_i.ready is high; the scan state is
// updated in the cycle of the transfer and its zero to two tokens are written
// into a 4-entry queue; out_o gives one token per cycle while out_o.ready holds.
// in_i.ready drops while fewer than two queue entries are free.
// Reset clears the scan state and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stream_tokenizer_fnv_hash (
  input  logic  clk_i,
  input  logic  rst_ni,
  bstok_in_if.sink    in_i,
  bstok_out_if.source out_o
);
  import bstok_pkg::*;

  // scan state
  mode_e            mode_q, mode_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  begin_q, begin_d;
  logic [63:0]      hash_q, hash_d;
  logic             dot_q, dot_d;
  logic [39:0]      kw_q, kw_d;
  logic [2:0]       kwcnt_q, kwcnt_d;
  logic             long_q, long_d;

  // result queue
  result_t          fifo_q [FifoDepth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;

  logic        in_fire, out_fire;
  logic [7:0]  b;
  logic        at_end, is_digit, is_dot, is_ws, is_an;
  logic [4:0]  pk, ik, num_kind;
  logic [31:0] span, pos32, begin32;
  logic [63:0] ident_hash, fnv_out;
  logic        run_idle;
  logic        pend_v, tail_v;
  result_t     pend, tail, r0, r1;
  logic [1:0]  push_n;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  assign b        = in_i.data_byte;
  assign at_end   = in_i.end_marker || (b == 8'd0);
  assign is_digit = (b >= 8'h30) && (b <= 8'h39);
  assign is_dot   = (b == ChDot);
  assign is_ws    = (b == ChSpace) || (b == ChTab) || (b == ChLf);
  assign is_an    = is_alnum(b);
  assign pk       = punct_kind(b);

  assign span       = 32'(pos_q - begin_q);
  assign pos32      = 32'(pos_q);
  assign begin32    = 32'(begin_q);
  assign num_kind   = dot_q ? KindDouble : KindInt;
  assign ik         = ident_kind(kw_q, long_q);
  assign ident_hash = (ik == KindIdent) ? hash_q : 64'd0;

  // a byte that ends a number, identifier or single-quoted token is scanned again from idle
  always_comb begin
    run_idle = 1'b0;
    if (!at_end) begin
      unique case (mode_q)
        ModeIdle:   run_idle = 1'b1;
        ModeNumber: run_idle = !is_digit && !is_dot;
        ModeIdent:  run_idle = !is_an;
        ModeQuoted: run_idle = is_ws || (b == ChCr);
        default:    run_idle = 1'b0;
      endcase
    end
  end

  // single hash unit: a fresh token starts from the offset basis
  assign fnv_out = fnv_step(run_idle ? FnvBasis : hash_q, b);

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q + 1'b1;
    begin_d = begin_q;
    hash_d  = hash_q;
    dot_d   = dot_q;
    kw_d    = kw_q;
    kwcnt_d = kwcnt_q;
    long_d  = long_q;
    pend_v  = 1'b0;
    pend    = make_result(KindEnd, pos32, 32'd0, 64'd0, StOk);
    tail_v  = 1'b0;
    tail    = make_result(KindEnd, pos32, 32'd0, 64'd0, StOk);

    if (at_end) begin
      unique case (mode_q)
        ModeNumber: begin
          pend_v = 1'b1;
          pend   = make_result(num_kind, begin32, span, hash_q, StOk);
        end
        ModeIdent: begin
          pend_v = 1'b1;
          pend   = make_result(ik, begin32, span, ident_hash, StOk);
        end
        ModeQuoted: begin
          pend_v = 1'b1;
          pend   = make_result(KindString, begin32, span, hash_q, StOk);
        end
        ModeString: begin
          pend_v = 1'b1;
          pend   = make_result(KindEnd, pos32, 32'd0, 64'd0, StUnterm);
        end
        ModeColon: begin
          pend_v = 1'b1;
          pend   = make_result(KindEnd, pos32, 32'd0, 64'd0, StColon);
        end
        default: ;
      endcase
      tail_v  = (mode_q != ModeHalt) && (mode_q != ModeString) && (mode_q != ModeColon);
      mode_d  = ModeIdle;
      pos_d   = '0;
      begin_d = '0;
      hash_d  = FnvBasis;
      dot_d   = 1'b0;
      kw_d    = '0;
      kwcnt_d = '0;
      long_d  = 1'b0;
    end else begin
      unique case (mode_q)
        ModeHalt, ModeIdle: ;
        ModeColon: begin
          pend_v = 1'b1;
          if (b == ChColon) begin
            pend   = make_result(KindDColon, begin32, 32'd2, 64'd0, StOk);
            mode_d = ModeIdle;
          end else begin
            pend   = make_result(KindEnd, pos32, 32'd0, 64'd0, StColon);
            mode_d = ModeHalt;
          end
        end
        ModeNumber: begin
          if (is_digit) begin
            hash_d = fnv_out;
          end else if (is_dot) begin
            if (dot_q) begin
              pend_v = 1'b1;
              pend   = make_result(KindEnd, pos32, 32'd0, 64'd0, StDot);
              mode_d = ModeHalt;
            end else begin
              dot_d  = 1'b1;
              hash_d = fnv_out;
            end
          end else begin
            pend_v = 1'b1;
            pend   = make_result(num_kind, begin32, span, hash_q, StOk);
          end
        end
        ModeIdent: begin
          if (is_an) begin
            hash_d = fnv_out;
            kw_d   = {kw_q[31:0], b};
            if (kwcnt_q < 3'd5) begin
              kwcnt_d = kwcnt_q + 3'd1;
            end else begin
              long_d = 1'b1;
            end
          end else begin
            pend_v = 1'b1;
            pend   = make_result(ik, begin32, span, ident_hash, StOk);
          end
        end
        ModeQuoted: begin
          if (run_idle) begin
            pend_v = 1'b1;
            pend   = make_result(KindString, begin32, span, hash_q, StOk);
          end else begin
            hash_d = fnv_out;
          end
        end
        ModeString: begin
          if (b == ChDquote) begin
            pend_v = 1'b1;
            pend   = make_result(KindString, begin32, span, hash_q, StOk);
            mode_d = ModeIdle;
          end else if (b[7]) begin
            pend_v = 1'b1;
            pend   = make_result(KindEnd, pos32, 32'd0, 64'd0, StUnterm);
            mode_d = ModeHalt;
          end else begin
            hash_d = fnv_out;
          end
        end
        ModeComment: begin
          if (b == ChLf) begin
            mode_d = ModeIdle;
          end else if (b[7]) begin
            pend_v = 1'b1;
            pend   = make_result(KindEnd, pos32, 32'd0, 64'd0, StUnexpected);
            mode_d = ModeHalt;
          end
        end
      endcase

      if (run_idle) begin
        priority if (is_ws) begin
          mode_d = ModeIdle;
        end else if (b == ChHash) begin
          mode_d = ModeComment;
        end else if (pk != KindEnd) begin
          tail_v = 1'b1;
          tail   = make_result(pk, pos32, 32'd1, 64'd0, StOk);
          mode_d = ModeIdle;
        end else if (b == ChColon) begin
          begin_d = pos_q;
          hash_d  = FnvBasis;
          mode_d  = ModeColon;
        end else if (b == ChSquote) begin
          begin_d = pos_q + 1'b1;
          hash_d  = FnvBasis;
          mode_d  = ModeQuoted;
        end else if (b == ChDquote) begin
          begin_d = pos_q + 1'b1;
          hash_d  = FnvBasis;
          mode_d  = ModeString;
        end else if (is_digit || is_dot) begin
          begin_d = pos_q;
          hash_d  = fnv_out;
          dot_d   = is_dot;
          mode_d  = ModeNumber;
        end else if (is_an) begin
          begin_d = pos_q;
          hash_d  = fnv_out;
          kw_d    = {32'd0, b};
          kwcnt_d = 3'd1;
          long_d  = 1'b0;
          mode_d  = ModeIdent;
        end else begin
          tail_v = 1'b1;
          tail   = make_result(KindEnd, pos32, 32'd0, 64'd0, StUnexpected);
          mode_d = ModeHalt;
        end
      end
    end
  end

  // order results: a token ended by this byte comes first
  always_comb begin
    r0      = pend_v ? pend : tail;
    r0.last = !(pend_v && tail_v);
    r1      = tail;
    r1.last = 1'b1;
    push_n  = {1'b0, pend_v} + {1'b0, tail_v};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      pos_q   <= '0;
      begin_q <= '0;
      hash_q  <= FnvBasis;
      dot_q   <= 1'b0;
      kw_q    <= '0;
      kwcnt_q <= '0;
      long_q  <= 1'b0;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
      hash_q  <= hash_d;
      dot_q   <= dot_d;
      kw_q    <= kw_d;
      kwcnt_q <= kwcnt_d;
      long_q  <= long_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (push_n != 2'd0)) begin
      fifo_q[wptr_q] <= r0;
    end
    if (in_fire && (push_n == 2'd2)) begin
      fifo_q[PtrW'(wptr_q + 1'b1)] <= r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (in_fire) begin
        wptr_q <= wptr_q + PtrW'(push_n);
      end
      if (out_fire) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (in_fire ? CntW'(push_n) : CntW'(0)) - CntW'(out_fire);
    end
  end

  assign in_i.ready         = (cnt_q <= CntW'(FifoDepth - 2));
  assign out_o.valid        = (cnt_q != '0);
  assign out_o.token_kind   = fifo_q[rptr_q].kind;
  assign out_o.token_start  = fifo_q[rptr_q].start;
  assign out_o.token_length = fifo_q[rptr_q].length;
  assign out_o.token_hash   = fifo_q[rptr_q].hash;
  assign out_o.status       = fifo_q[rptr_q].status;
  assign out_o.last_of_run  = fifo_q[rptr_q].last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("result queue count out of range");

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && at_end) |=> (mode_q == ModeIdle && pos_q == '0))
    else $error("scan state not cleared after end of input");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mode_q == ModeHalt) |-> (push_n == 2'd0))
    else $error("halted scanner produced a token");

  a_status_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != StOk) |-> (out_o.token_kind == KindEnd))
    else $error("error status on a non-end token");

  a_pair_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last_of_run) |-> (cnt_q >= CntW'(2)))
    else $error("first token of a pair without its partner queued");

endmodule

`default_nettype wire
